>>> design/hsfd_pkg.sv
// Shared types and constants for the humidity sensor frame decoder.
// No dependencies; imported by every module of the block except hsfd_checker.
`default_nettype none

package hsfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Conversion scales, result in hundredths
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [14:0] HUM_SCALE   = 15'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;

  // Byte slot within the six-byte reply
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_t;

  // Completed reply handed from the byte tracker to the converter
  typedef struct packed {
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic        crc_ok;
  } frame_t;

  // One byte of CRC-8, MSB first, unrolled
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/hsfd_frame.sv
// Byte tracker: slot counter, running CRC-8 and word capture for one reply.
// Depends on hsfd_pkg. Holds one completed frame until the converter takes it.
`default_nettype none

module hsfd_frame (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      in_rx_byte,
  input  wire logic            in_frame_start,
  output hsfd_pkg::frame_t     frm,
  output logic                 frm_valid,
  input  wire logic            frm_take
);
  import hsfd_pkg::*;

  pos_t        pos_r, pos_nxt, pos;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] tword_r, tword_nxt;
  logic [15:0] hword_r, hword_nxt;
  logic        first_ok_r, first_ok_nxt;
  frame_t      frm_r, frm_nxt;
  logic        frm_valid_r, frm_valid_nxt;
  logic        accept;
  logic        frm_load;

  // Only stall while a finished frame is parked and cannot move on
  assign in_stall  = frm_valid_r & ~frm_take;
  assign accept    = in_valid & ~in_stall;
  assign frm       = frm_r;
  assign frm_valid = frm_valid_r;

  always_comb begin
    pos          = in_frame_start ? POS_T_HI : pos_r;
    if (pos > POS_H_CRC) begin
      pos = POS_T_HI;
    end
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    hold_nxt     = hold_r;
    tword_nxt    = tword_r;
    hword_nxt    = hword_r;
    first_ok_nxt = first_ok_r;
    frm_nxt      = frm_r;
    frm_load     = 1'b0;
    if (accept) begin
      unique case (pos)
        POS_T_HI: begin
          crc_nxt  = crc8_byte(CRC_INIT, in_rx_byte);
          hold_nxt = in_rx_byte;
          pos_nxt  = POS_T_LO;
        end
        POS_H_HI: begin
          crc_nxt  = crc8_byte(CRC_INIT, in_rx_byte);
          hold_nxt = in_rx_byte;
          pos_nxt  = POS_H_LO;
        end
        POS_T_LO: begin
          crc_nxt   = crc8_byte(crc_r, in_rx_byte);
          tword_nxt = {hold_r, in_rx_byte};
          pos_nxt   = POS_T_CRC;
        end
        POS_T_CRC: begin
          first_ok_nxt = (crc_r == in_rx_byte);
          crc_nxt      = CRC_INIT;
          pos_nxt      = POS_H_HI;
        end
        POS_H_LO: begin
          crc_nxt   = crc8_byte(crc_r, in_rx_byte);
          hword_nxt = {hold_r, in_rx_byte};
          pos_nxt   = POS_H_CRC;
        end
        POS_H_CRC: begin
          frm_nxt.temp_word = tword_r;
          frm_nxt.hum_word  = hword_r;
          frm_nxt.crc_ok    = first_ok_r & (crc_r == in_rx_byte);
          frm_load          = 1'b1;
          crc_nxt           = CRC_INIT;
          pos_nxt           = POS_T_HI;
        end
        default: begin
          pos_nxt = POS_T_HI;
        end
      endcase
    end
  end

  always_comb begin
    if (frm_load) begin
      frm_valid_nxt = 1'b1;
    end else if (frm_take) begin
      frm_valid_nxt = 1'b0;
    end else begin
      frm_valid_nxt = frm_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_T_HI;
      crc_r       <= CRC_INIT;
      hold_r      <= '0;
      tword_r     <= '0;
      hword_r     <= '0;
      first_ok_r  <= 1'b0;
      frm_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      hold_r      <= hold_nxt;
      tword_r     <= tword_nxt;
      hword_r     <= hword_nxt;
      first_ok_r  <= first_ok_nxt;
      frm_valid_r <= frm_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frm_r <= frm_nxt;
  end

endmodule

`default_nettype wire

>>> design/hsfd_conv.sv
// Converter: raw words to hundredths of a degree / percent, into the result register.
// Depends on hsfd_pkg. One constant multiply per word, divide by 65535 via shift-and-fold.
`default_nettype none

module hsfd_conv (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              frm_valid,
  input  wire hsfd_pkg::frame_t  frm,
  output logic                   frm_take,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [14:0]     out_temperature_centi,
  output logic [13:0]            out_humidity_centi,
  output logic                   out_crc_ok
);
  import hsfd_pkg::*;

  // round(mult * raw / 65535); no exact halves since 65535 is odd.
  // x = q0*65536 + lo = q0*65535 + (lo + q0), and lo + q0 < 2*65535.
  function automatic logic [14:0] scale_round(input logic [15:0] raw,
                                              input logic [14:0] mult);
    logic [30:0] x;
    logic [14:0] q0;
    logic [16:0] rem;
    x   = 31'(mult * raw) + 31'd32767;
    q0  = x[30:16];
    rem = {1'b0, x[15:0]} + {2'b00, q0};
    return q0 + ((rem >= 17'd65535) ? 15'd1 : 15'd0);
  endfunction

  logic              out_valid_r, out_valid_nxt;
  logic [14:0]       temp_r, temp_nxt;
  logic [13:0]       hum_r, hum_nxt;
  logic              ok_r;
  logic [14:0]       hum_q;

  assign frm_take = ~out_valid_r | ~out_stall;

  always_comb begin
    temp_nxt      = scale_round(frm.temp_word, TEMP_SCALE) - TEMP_OFFSET;
    hum_q         = scale_round(frm.hum_word, HUM_SCALE);
    hum_nxt       = hum_q[13:0];
    out_valid_nxt = frm_take ? frm_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_take && frm_valid) begin
      temp_r <= temp_nxt;
      hum_r  <= hum_nxt;
      ok_r   <= frm.crc_ok;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = signed'(temp_r);
  assign out_humidity_centi    = hum_r;
  assign out_crc_ok            = ok_r;

endmodule

`default_nettype wire

>>> design/humidity_sensor_frame_decoder.sv
// Top level of the humidity sensor frame decoder: byte tracker plus converter.
// Depends on hsfd_pkg, hsfd_frame and hsfd_conv.
//
// Takes one reply byte per cycle unless stalled (temperature hi/lo/CRC, humidity
// hi/lo/CRC). The CRC-8 tracker handles each byte and registers a completed frame
// at the edge that accepts the sixth byte; the converter stage (constant multiply
// and divide by 65535) is combinational and feeds the output register, which loads
// the result when the converter takes the frame. Input stalls only when a completed
// frame and a pending result are both held while the output side stalls.
// in_frame_start forces the byte to be taken as the first of a new reply.
`default_nettype none

module humidity_sensor_frame_decoder (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_rx_byte,
  input  wire logic          in_frame_start,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic signed [14:0] out_temperature_centi,
  output logic [13:0]        out_humidity_centi,
  output logic               out_crc_ok
);
  import hsfd_pkg::*;

  frame_t frm;
  logic   frm_valid;
  logic   frm_take;

  hsfd_frame u_frame (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .in_frame_start (in_frame_start),
    .frm            (frm),
    .frm_valid      (frm_valid),
    .frm_take       (frm_take)
  );

  hsfd_conv u_conv (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .frm_valid             (frm_valid),
    .frm                   (frm),
    .frm_take              (frm_take),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_temperature_centi (out_temperature_centi),
    .out_humidity_centi    (out_humidity_centi),
    .out_crc_ok            (out_crc_ok)
  );

endmodule

`default_nettype wire

>>> design/hsfd_checker.sv
// Port-level checks for the humidity sensor frame decoder, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module hsfd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [14:0] out_temperature_centi,
  input wire logic [13:0] out_humidity_centi,
  input wire logic        out_crc_ok
);

  // Result never appears right out of reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Held transaction keeps its payload while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_temperature_centi)
      && $stable(out_humidity_centi) && $stable(out_crc_ok))
    else $error("stalled result changed");

  // Input back-pressure only comes from a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_humidity_centi <= 14'd10000)
    else $error("humidity out of range");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_temperature_centi) >= -15'sd4500
      && $signed(out_temperature_centi) <= 15'sd13000)
    else $error("temperature out of range");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_stall              (in_stall),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_temperature_centi (out_temperature_centi),
  .out_humidity_centi    (out_humidity_centi),
  .out_crc_ok            (out_crc_ok)
);

`default_nettype wire

>>> tb/tb_humidity_sensor_frame_decoder.sv
// Self-checking testbench for humidity_sensor_frame_decoder: drives reply bytes with
// random gaps and output stalls, and predicts every decoded reading independently.
// Depends on hsfd_pkg (byte slot enum) and the decoder RTL.
`timescale 1ns / 100ps

module tb_humidity_sensor_frame_decoder;
  import hsfd_pkg::*;

  localparam logic [7:0]      CRC8_SEED  = 8'hFF;
  localparam logic [7:0]      CRC8_GEN   = 8'h31;
  localparam longint unsigned FULL_SCALE = 65535;
  localparam int unsigned     T_SPAN     = 17500;
  localparam int unsigned     H_SPAN     = 10000;
  localparam int              T_OFFSET   = 4500;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } rx_item_t;

  typedef struct packed {
    logic signed [14:0] temp;
    logic [13:0]        hum;
    logic               ok;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               in_frame_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [14:0] out_temperature_centi;
  logic [13:0]        out_humidity_centi;
  logic               out_crc_ok;

  rx_item_t pending_bytes[$];
  reading_t expected_readings[$];
  int       bytes_queued = 0;
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int       hold_left = 0;
  logic     in_taken = 1'b0;

  // decoder state mirror
  logic [2:0]  trk_pos = POS_T_HI;
  logic [7:0]  trk_crc = CRC8_SEED;
  logic [7:0]  trk_hi = 8'h00;
  logic [15:0] trk_temp = 16'h0000;
  logic [15:0] trk_hum = 16'h0000;
  logic        trk_t_ok = 1'b0;

  humidity_sensor_frame_decoder dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .in_frame_start       (in_frame_start),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_temperature_centi(out_temperature_centi),
    .out_humidity_centi   (out_humidity_centi),
    .out_crc_ok           (out_crc_ok)
  );

  always #5 clk = ~clk;

  // bit-serial form of the CRC-8 shift register
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ d[i];
      c = {c[6:0], 1'b0} ^ (fb ? CRC8_GEN : 8'h00);
    end
    return c;
  endfunction

  // round(span * raw / 65535); no exact halves since 65535 is odd
  function automatic int unsigned to_centi(input logic [15:0] raw, input int unsigned span);
    longint unsigned num;
    num = span;
    num = 2 * num * raw + FULL_SCALE;
    return int'(num / (2 * FULL_SCALE));
  endfunction

  task automatic track_byte(input logic [7:0] b, input logic start);
    logic [2:0] slot;
    reading_t   r;
    int         t;
    slot = trk_pos;
    if (start || slot > POS_H_CRC) slot = POS_T_HI;
    case (pos_t'(slot))
      POS_T_HI, POS_H_HI: begin
        trk_crc = crc8_next(CRC8_SEED, b);
        trk_hi  = b;
        trk_pos = slot + 3'd1;
      end
      POS_T_LO: begin
        trk_crc  = crc8_next(trk_crc, b);
        trk_temp = {trk_hi, b};
        trk_pos  = POS_T_CRC;
      end
      POS_T_CRC: begin
        trk_t_ok = (trk_crc == b);
        trk_crc  = CRC8_SEED;
        trk_pos  = POS_H_HI;
      end
      POS_H_LO: begin
        trk_crc = crc8_next(trk_crc, b);
        trk_hum = {trk_hi, b};
        trk_pos = POS_H_CRC;
      end
      POS_H_CRC: begin
        t      = int'(to_centi(trk_temp, T_SPAN)) - T_OFFSET;
        r.temp = t[14:0];
        r.hum  = 14'(to_centi(trk_hum, H_SPAN));
        r.ok   = trk_t_ok && (trk_crc == b);
        expected_readings.push_back(r);
        trk_crc = CRC8_SEED;
        trk_pos = POS_T_HI;
      end
      default: ;
    endcase
  endtask

  // acceptance tracking, prediction and result checking
  always @(posedge clk) begin : monitor
    reading_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction: expected none, actual temp %0d hum %0d ok %0b",
                   $time, out_temperature_centi, out_humidity_centi, out_crc_ok);
        end else begin
          want = expected_readings.pop_front();
          if (out_temperature_centi !== want.temp) begin
            mismatches++;
            $display("%0t: temperature_centi expected %0d actual %0d",
                     $time, want.temp, out_temperature_centi);
          end
          if (out_humidity_centi !== want.hum) begin
            mismatches++;
            $display("%0t: humidity_centi expected %0d actual %0d",
                     $time, want.hum, out_humidity_centi);
          end
          if (out_crc_ok !== want.ok) begin
            mismatches++;
            $display("%0t: crc_ok expected %0b actual %0b", $time, want.ok, out_crc_ok);
          end
        end
      end
      if (in_valid && !in_stall) track_byte(in_rx_byte, in_frame_start);
    end
  end

  // byte driver: holds the payload until it is taken
  always @(negedge clk) begin : driver
    rx_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled, keep everything
    end else if (pending_bytes.size() == 0 || $urandom_range(99) < send_idle_pct) begin
      in_valid       <= 1'b0;
      in_rx_byte     <= 8'($urandom);
      in_frame_start <= 1'($urandom);
    end else begin
      nxt = pending_bytes.pop_front();
      in_valid       <= 1'b1;
      in_rx_byte     <= nxt.data;
      in_frame_start <= nxt.start;
    end
  end

  // receiver back-pressure; a long hold-off overrides the random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic start);
    rx_item_t it;
    it.data  = b;
    it.start = start;
    pending_bytes.push_back(it);
    bytes_queued++;
  endtask

  // keep < 6 gives a truncated reply
  task automatic queue_frame(input logic [15:0] tw, input logic [15:0] hw, input logic flag,
                             input logic bad_t, input logic bad_h, input int keep);
    logic [7:0] b [6];
    logic [7:0] tc;
    logic [7:0] hc;
    tc = crc8_next(crc8_next(CRC8_SEED, tw[15:8]), tw[7:0]);
    hc = crc8_next(crc8_next(CRC8_SEED, hw[15:8]), hw[7:0]);
    if (bad_t) tc ^= 8'($urandom_range(1, 255));
    if (bad_h) hc ^= 8'($urandom_range(1, 255));
    b = '{tw[15:8], tw[7:0], tc, hw[15:8], hw[7:0], hc};
    for (int i = 0; i < keep; i++) queue_byte(b[i], flag && i == 0);
  endtask

  function automatic logic [15:0] pick_word();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return 16'h0000;
    if (sel < 16) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_readings.size() != 0);
  endtask

  task automatic run_phase(input int idle, input int stall, input int hold, input int count);
    int goal;
    int sel;
    send_idle_pct = idle;
    stall_pct     = stall;
    hold_left     = hold;
    goal = bytes_queued + count;
    while (bytes_queued < goal) begin
      sel = $urandom_range(99);
      if (sel < 75) begin
        queue_frame(pick_word(), pick_word(), $urandom_range(99) < 80,
                    $urandom_range(99) < 15, $urandom_range(99) < 15, 6);
      end else if (sel < 90) begin
        queue_frame(pick_word(), pick_word(), 1'b1, 1'b0, 1'b0, $urandom_range(1, 5));
      end else begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom), $urandom_range(99) < 30);
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // scale extremes, frame following a complete one without a start flag,
    // restart mid-frame, and each check failing on its own
    queue_frame(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0, 6);
    queue_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 6);
    queue_frame(16'h1234, 16'h5678, 1'b1, 1'b0, 1'b0, 3);
    queue_frame(16'h6666, 16'h8000, 1'b1, 1'b1, 1'b0, 6);
    queue_frame(16'h7FFF, 16'hAAAA, 1'b1, 1'b0, 1'b1, 6);
    wait_drained();

    run_phase(0, 0, 300, 170);
    run_phase(60, 0, 0, 170);
    run_phase(0, 60, 0, 170);
    run_phase(22, 22, 0, 170);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
design/hsfd_pkg.sv
design/hsfd_frame.sv
design/hsfd_conv.sv
design/humidity_sensor_frame_decoder.sv
design/hsfd_checker.sv
tb/tb_humidity_sensor_frame_decoder.sv
